/* hdl/obs_pkg.sv */
`timescale 1ns / 1ps

package obs_pkg;

   // full scale of the wheel pwm compare value
   localparam int unsigned PWM_FULL_SCALE = 1000;

   localparam int unsigned DUTY_W   = 10;
   localparam int unsigned ECHO_W   = 15;
   localparam int unsigned MS_W     = 10;
   localparam int unsigned SAMPLE_W = 9;
   localparam int unsigned HIT_W    = 2;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 15;

   localparam logic [MS_W-1:0]     BRAKE_MS       = MS_W'(150);
   localparam logic [MS_W-1:0]     STRAIGHT_MS    = MS_W'(120);
   localparam logic [MS_W-1:0]     SAMPLE_MS      = MS_W'(10);
   localparam logic [MS_W-1:0]     BLINK_MS       = MS_W'(100);
   localparam logic [SAMPLE_W-1:0] SEEK_LIMIT     = SAMPLE_W'(300);
   localparam logic [HIT_W-1:0]    HITS_NEEDED    = HIT_W'(2);
   localparam logic [DUTY_W-1:0]   STRAIGHT_LEFT  = DUTY_W'(480);
   localparam logic [DUTY_W-1:0]   STRAIGHT_RIGHT = DUTY_W'(150);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_STOP_ECHO_LIMIT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_RUN        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_FAST       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_SLOW       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_LEFT_INNER = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_VEER_RIGHT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_TIME_PASS        = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_RETURN_TURN_MS   = 3'd7;

   typedef enum logic [3:0] {
      PH_CRUISE   = 4'd0,
      PH_BRAKE    = 4'd1,
      PH_VEER     = 4'd2,
      PH_PASS     = 4'd3,
      PH_TURN     = 4'd4,
      PH_SEEK     = 4'd5,
      PH_STRAIGHT = 4'd6,
      PH_DONE     = 4'd7,
      PH_FAILED   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [ECHO_W-1:0] stop_echo_limit;
      logic [DUTY_W-1:0] speed_run;
      logic [DUTY_W-1:0] speed_fast;
      logic [DUTY_W-1:0] speed_slow;
      logic [DUTY_W-1:0] speed_left_inner;
      logic [MS_W-1:0]   time_veer_right;
      logic [MS_W-1:0]   time_pass;
      logic [MS_W-1:0]   return_turn_ms;
   } cfg_type;

   typedef struct packed {
      logic [3:0]        line_sensors;
      logic              echo_ready;
      logic [ECHO_W-1:0] echo_us;
      logic              echo_timeout;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] left_duty;
      logic              left_forward;
      logic [DUTY_W-1:0] right_duty;
      logic              right_forward;
      logic              led_on;
      logic [3:0]        phase_now;
   } rsp_type;

   function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
      logic [DUTY_W-1:0] v;
      begin
         v = (32'(d) > PWM_FULL_SCALE) ? DUTY_W'(PWM_FULL_SCALE) : d;
         return v;
      end
   endfunction

endpackage

/* hdl/obs_if.sv */
`timescale 1ns / 1ps

interface obs_req_if;
   logic                          valid;
   logic                          ready;
   logic [3:0]                    line_sensors;
   logic                          echo_ready;
   logic [obs_pkg::ECHO_W-1:0]    echo_us;
   logic                          echo_timeout;

   modport source (output valid, line_sensors, echo_ready, echo_us, echo_timeout,
                   input ready);
   modport sink   (input valid, line_sensors, echo_ready, echo_us, echo_timeout,
                   output ready);
endinterface

interface obs_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [obs_pkg::DUTY_W-1:0]    left_duty;
   logic                          left_forward;
   logic [obs_pkg::DUTY_W-1:0]    right_duty;
   logic                          right_forward;
   logic                          led_on;
   logic [3:0]                    phase_now;

   modport source (output valid, left_duty, left_forward, right_duty, right_forward,
                   led_on, phase_now, input ready);
   modport sink   (input valid, left_duty, left_forward, right_duty, right_forward,
                   led_on, phase_now, output ready);
endinterface

/* hdl/obs_regs.sv */
`timescale 1ns / 1ps

module obs_regs (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [obs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [obs_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output obs_pkg::cfg_type                  cfg
);

   obs_pkg::cfg_type cfg_ff;
   obs_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            obs_pkg::REG_STOP_ECHO_LIMIT:  cfg_in.stop_echo_limit  = csr_write_data;
            obs_pkg::REG_SPEED_RUN:        cfg_in.speed_run        = csr_write_data[9:0];
            obs_pkg::REG_SPEED_FAST:       cfg_in.speed_fast       = csr_write_data[9:0];
            obs_pkg::REG_SPEED_SLOW:       cfg_in.speed_slow       = csr_write_data[9:0];
            obs_pkg::REG_SPEED_LEFT_INNER: cfg_in.speed_left_inner = csr_write_data[9:0];
            obs_pkg::REG_TIME_VEER_RIGHT:  cfg_in.time_veer_right  = csr_write_data[9:0];
            obs_pkg::REG_TIME_PASS:        cfg_in.time_pass        = csr_write_data[9:0];
            obs_pkg::REG_RETURN_TURN_MS:   cfg_in.return_turn_ms   = csr_write_data[9:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.stop_echo_limit  <= 15'd696;
         cfg_ff.speed_run        <= 10'd300;
         cfg_ff.speed_fast       <= 10'd460;
         cfg_ff.speed_slow       <= 10'd130;
         cfg_ff.speed_left_inner <= 10'd60;
         cfg_ff.time_veer_right  <= 10'd150;
         cfg_ff.time_pass        <= 10'd480;
         cfg_ff.return_turn_ms   <= 10'd380;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/obs_ctrl.sv */
`timescale 1ns / 1ps

module obs_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  obs_pkg::req_type   item,
   input  obs_pkg::cfg_type   cfg,
   output obs_pkg::rsp_type   result
);

   obs_pkg::phase_type                 phase_ff, phase_in;
   logic [obs_pkg::MS_W-1:0]           ms_ff, ms_in;
   logic [obs_pkg::SAMPLE_W-1:0]       samples_ff, samples_in;
   logic [obs_pkg::HIT_W-1:0]          hits_ff, hits_in;
   logic                               blink_ff, blink_in;

   obs_pkg::phase_type                 cur;
   logic [obs_pkg::MS_W-1:0]           ms_cur;
   logic [obs_pkg::MS_W:0]             ms_inc;
   logic [obs_pkg::SAMPLE_W-1:0]       samples_inc;
   logic [obs_pkg::HIT_W-1:0]          hits_inc;
   logic [obs_pkg::DUTY_W-1:0]         ld, rd, ld_sat, rd_sat;
   logic                               led;
   logic [3:0]                         shown;
   logic                               trigger;

   always_comb begin
      trigger = (phase_ff == obs_pkg::PH_CRUISE) && item.echo_ready && !item.echo_timeout &&
                (item.echo_us != '0) && (item.echo_us <= cfg.stop_echo_limit);
      cur    = trigger ? obs_pkg::PH_BRAKE : phase_ff;
      ms_cur = trigger ? '0 : ms_ff;
      ms_inc = {1'b0, ms_cur} + 1'b1;
      samples_inc = samples_ff + 1'b1;
      hits_inc = (hits_ff < obs_pkg::HITS_NEEDED) ? hits_ff + 1'b1 : hits_ff;

      phase_in   = cur;
      ms_in      = ms_cur;
      samples_in = samples_ff;
      hits_in    = hits_ff;
      blink_in   = blink_ff;
      ld    = '0;
      rd    = '0;
      led   = 1'b1;
      shown = 4'(cur);

      unique case (cur)
         obs_pkg::PH_CRUISE: begin
            ld  = cfg.speed_run;
            rd  = cfg.speed_run;
            led = 1'b0;
         end
         obs_pkg::PH_BRAKE: begin
            ms_in = ms_inc[obs_pkg::MS_W-1:0];
            if (ms_inc >= {1'b0, obs_pkg::BRAKE_MS}) begin
               phase_in = obs_pkg::PH_VEER;
               ms_in    = '0;
            end
         end
         obs_pkg::PH_VEER: begin
            ld    = cfg.speed_fast;
            rd    = cfg.speed_slow;
            ms_in = ms_inc[obs_pkg::MS_W-1:0];
            if (ms_inc >= {1'b0, cfg.time_veer_right}) begin
               phase_in = obs_pkg::PH_PASS;
               ms_in    = '0;
            end
         end
         obs_pkg::PH_PASS: begin
            ld    = cfg.speed_run;
            rd    = cfg.speed_run;
            ms_in = ms_inc[obs_pkg::MS_W-1:0];
            if (ms_inc >= {1'b0, cfg.time_pass}) begin
               phase_in = obs_pkg::PH_TURN;
               ms_in    = '0;
            end
         end
         obs_pkg::PH_TURN: begin
            ld    = cfg.speed_left_inner;
            rd    = cfg.speed_fast;
            ms_in = ms_inc[obs_pkg::MS_W-1:0];
            if (ms_inc >= {1'b0, cfg.return_turn_ms}) begin
               phase_in   = obs_pkg::PH_SEEK;
               ms_in      = '0;
               samples_in = '0;
               hits_in    = '0;
            end
         end
         obs_pkg::PH_SEEK: begin
            ld = cfg.speed_run;
            rd = cfg.speed_run;
            // sample on the first tick of each slot
            if ((ms_cur == '0) && (item.line_sensors != '0) &&
                (hits_inc >= obs_pkg::HITS_NEEDED)) begin
               hits_in  = hits_inc;
               phase_in = obs_pkg::PH_STRAIGHT;
               ms_in    = '0;
            end else begin
               if (ms_cur == '0) begin
                  hits_in = (item.line_sensors != '0) ? hits_inc : '0;
               end
               ms_in = ms_inc[obs_pkg::MS_W-1:0];
               if (ms_inc >= {1'b0, obs_pkg::SAMPLE_MS}) begin
                  ms_in      = '0;
                  samples_in = samples_inc;
                  if (samples_inc >= obs_pkg::SEEK_LIMIT) begin
                     phase_in = obs_pkg::PH_FAILED;
                     blink_in = 1'b1;
                  end
               end
            end
         end
         obs_pkg::PH_STRAIGHT: begin
            ld    = obs_pkg::STRAIGHT_LEFT;
            rd    = obs_pkg::STRAIGHT_RIGHT;
            ms_in = ms_inc[obs_pkg::MS_W-1:0];
            if (ms_inc >= {1'b0, obs_pkg::STRAIGHT_MS}) begin
               phase_in = obs_pkg::PH_DONE;
               ms_in    = '0;
            end
         end
         obs_pkg::PH_FAILED: begin
            led   = blink_ff;
            ms_in = ms_inc[obs_pkg::MS_W-1:0];
            if (ms_inc >= {1'b0, obs_pkg::BLINK_MS}) begin
               ms_in    = '0;
               blink_in = ~blink_ff;
            end
         end
         default: begin
            // done, and any code that cannot be reached
            shown = 4'(obs_pkg::PH_DONE);
         end
      endcase

      ld_sat = obs_pkg::sat_duty(ld);
      rd_sat = obs_pkg::sat_duty(rd);
      result.left_duty     = ld_sat;
      result.left_forward  = (ld_sat != '0);
      result.right_duty    = rd_sat;
      result.right_forward = (rd_sat != '0);
      result.led_on        = led;
      result.phase_now     = shown;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= obs_pkg::PH_CRUISE;
         ms_ff      <= '0;
         samples_ff <= '0;
         hits_ff    <= '0;
         blink_ff   <= 1'b0;
      end else if (step) begin
         phase_ff   <= phase_in;
         ms_ff      <= ms_in;
         samples_ff <= samples_in;
         hits_ff    <= hits_in;
         blink_ff   <= blink_in;
      end
   end

endmodule

/* hdl/obstacle_bypass_sequencer.sv */
`timescale 1ns / 1ps
// channel | direction | handshake     | payload
// req     | in        | valid / ready | line_sensors, echo_ready, echo_us, echo_timeout
// rsp     | out       | valid / ready | left_duty, left_forward, right_duty,
//         |           |               | right_forward, led_on, phase_now
// csr     | in        | write enable  | index (3b), write data (15b)
//
// one tick item per cycle sustained while rsp ready stays high; a tick is held in the input
// register, then its result in the result register (input register, then result register),
// and the result is presented from there; the sequencer state updates as the result loads
// reset is synchronous and active high: cruise phase, registers back to their defaults
// a stalled result holds in the result register while the input register takes one more tick

module obstacle_bypass_sequencer (
   input  logic                              clock,
   input  logic                              reset,
   obs_req_if.sink                           req,
   obs_rsp_if.source                         rsp,
   input  logic                              csr_write_enable,
   input  logic [obs_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [obs_pkg::CSR_DATA_W-1:0]    csr_write_data
);

   obs_pkg::cfg_type cfg;

   // input register
   logic             in_valid_ff, in_valid_in;
   obs_pkg::req_type in_item_ff;

   // result register
   logic             out_valid_ff, out_valid_in;
   obs_pkg::rsp_type out_item_ff;
   obs_pkg::rsp_type result;

   logic             advance;
   logic             req_xfer;

   // a tick moves to the result register when that register is empty or being drained
   assign advance  = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_xfer = req.valid && req.ready;

   assign in_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);

   obs_regs u_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // phase sequencer: state steps once per tick that reaches the result register
   obs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers carry no reset
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_item_ff.line_sensors <= req.line_sensors;
         in_item_ff.echo_ready   <= req.echo_ready;
         in_item_ff.echo_us      <= req.echo_us;
         in_item_ff.echo_timeout <= req.echo_timeout;
      end
      if (advance) begin
         out_item_ff <= result;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.left_duty     = out_item_ff.left_duty;
   assign rsp.left_forward  = out_item_ff.left_forward;
   assign rsp.right_duty    = out_item_ff.right_duty;
   assign rsp.right_forward = out_item_ff.right_forward;
   assign rsp.led_on        = out_item_ff.led_on;
   assign rsp.phase_now     = out_item_ff.phase_now;

endmodule

/* dv/obstacle_bypass_sequencer_tb.sv */
`timescale 1ns / 1ps

module obstacle_bypass_sequencer_tb;
   import obs_pkg::*;

   // run limit, far above the slowest legal run
   localparam int CYCLE_LIMIT = 500000;
   // cruise items per register setting
   localparam int CRUISE_TICKS = 250;
   // items sent after the sequence has settled in its end state
   localparam int TAIL_TICKS = 350;
   // sequence items between register rewrites
   localparam int REWRITE_EVERY = 97;

   // one row of the opening stimulus table
   typedef struct packed {
      req_type stim;
      logic    typed;
      rsp_type want;
   } tick_row_type;

   // cruise drive with the registers at their reset values
   localparam rsp_type CRUISE_AT_RESET =
      '{10'd300, 1'b1, 10'd300, 1'b1, 1'b0, 4'(PH_CRUISE)};
   // the tick that carries the triggering echo already brakes with the lamp lit
   localparam rsp_type BRAKE_SHOWN = '{10'd0, 1'b0, 10'd0, 1'b0, 1'b1, 4'(PH_BRAKE)};

   // cruise corner cases under reset registers, none of them may start the bypass
   localparam tick_row_type OPENING_TICKS [10] = '{
      // nothing arrives
      '{'{4'h0, 1'b0, 15'd0, 1'b0}, 1'b1, CRUISE_AT_RESET},
      // all probes on, stale full-width echo that also timed out
      '{'{4'hF, 1'b0, 15'h7FFF, 1'b1}, 1'b1, CRUISE_AT_RESET},
      // zero echo width
      '{'{4'h1, 1'b1, 15'd0, 1'b0}, 1'b1, CRUISE_AT_RESET},
      // timed-out echo inside the window
      '{'{4'h2, 1'b1, 15'd300, 1'b1}, 1'b1, CRUISE_AT_RESET},
      // one past the limit
      '{'{4'h4, 1'b1, 15'd697, 1'b0}, 1'b1, CRUISE_AT_RESET},
      // widest echo
      '{'{4'h8, 1'b1, 15'h7FFF, 1'b0}, 1'b1, CRUISE_AT_RESET},
      // in-window width but no fresh measurement
      '{'{4'h0, 1'b0, 15'd1, 1'b0}, 1'b1, CRUISE_AT_RESET},
      // alternating bit patterns
      '{'{4'hA, 1'b1, 15'h5555, 1'b0}, 1'b1, CRUISE_AT_RESET},
      '{'{4'h5, 1'b1, 15'h2AAA, 1'b1}, 1'b0, '0},
      '{'{4'h3, 1'b1, 15'd698, 1'b0}, 1'b0, '0}
   };

   // fixed register settings for cruise, the extremes first
   localparam cfg_type CRUISE_SETTINGS [3] = '{
      '{15'd0, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0},
      '{15'h7FFF, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023, 10'd0, 10'd1023},
      '{15'd1, 10'd1000, 10'd1000, 10'd1, 10'd999, 10'd1, 10'd1, 10'd1}
   };

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   obs_req_if req();
   obs_rsp_if rsp();

   obstacle_bypass_sequencer DUT (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .rsp              (rsp),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // predictor copy of the block state and registers
   cfg_type             cfg;
   phase_type           bp_phase;
   logic [MS_W-1:0]     phase_ms;
   logic [SAMPLE_W-1:0] seek_count;
   logic [HIT_W-1:0]    hit_run;
   logic                lamp_blink;

   // wheel drive results still owed by the block, oldest first
   rsp_type expected_drive [$];

   int ticks_sent     = 0;
   int drives_checked = 0;
   int mismatch_count = 0;
   int reg_writes     = 0;
   int cycle_count    = 0;
   // 0 no idling, 1 sender gaps, 2 receiver stalls, 3 light idling on both sides
   int idle_mode      = 0;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------------
   // predictor
   // ---------------------------------------------------------------------------------

   task automatic enter_phase(input phase_type nxt);
      bp_phase = nxt;
      phase_ms = '0;
   endtask

   // one ms of a timed phase, leave after dur ms (a zero duration still takes one tick)
   task automatic count_ms(input logic [MS_W-1:0] dur, input phase_type nxt);
      phase_ms = phase_ms + 1'b1;
      if (phase_ms >= dur)
         enter_phase(nxt);
   endtask

   function automatic logic starts_bypass(input req_type t);
      return bp_phase == PH_CRUISE && t.echo_ready && !t.echo_timeout &&
             t.echo_us != '0 && t.echo_us <= cfg.stop_echo_limit;
   endfunction

   // one 1 ms tick through the sequencer, gives the drive shown on that tick
   task automatic advance_bypass(input req_type t, output rsp_type r);
      logic [DUTY_W-1:0] ld;
      logic [DUTY_W-1:0] rd;
      logic              lamp;
      phase_type         shown;
      logic              line_found;
      ld = '0;
      rd = '0;
      lamp = 1'b1;
      line_found = 1'b0;
      if (starts_bypass(t))
         enter_phase(PH_BRAKE);
      shown = bp_phase;
      case (bp_phase)
         PH_CRUISE: begin
            ld = cfg.speed_run;
            rd = cfg.speed_run;
            lamp = 1'b0;
         end
         PH_BRAKE: count_ms(BRAKE_MS, PH_VEER);
         PH_VEER: begin
            ld = cfg.speed_fast;
            rd = cfg.speed_slow;
            count_ms(cfg.time_veer_right, PH_PASS);
         end
         PH_PASS: begin
            ld = cfg.speed_run;
            rd = cfg.speed_run;
            count_ms(cfg.time_pass, PH_TURN);
         end
         PH_TURN: begin
            ld = cfg.speed_left_inner;
            rd = cfg.speed_fast;
            // last turn tick clears the seek counters
            if ({1'b0, phase_ms} + 1'b1 >= {1'b0, cfg.return_turn_ms}) begin
               seek_count = '0;
               hit_run = '0;
            end
            count_ms(cfg.return_turn_ms, PH_SEEK);
         end
         PH_SEEK: begin
            ld = cfg.speed_run;
            rd = cfg.speed_run;
            // probes only count on the first tick of each sample slot
            if (phase_ms == '0) begin
               if (t.line_sensors != '0) begin
                  if (hit_run < HITS_NEEDED)
                     hit_run = hit_run + 1'b1;
                  if (hit_run >= HITS_NEEDED) begin
                     enter_phase(PH_STRAIGHT);
                     line_found = 1'b1;
                  end
               end else begin
                  hit_run = '0;
               end
            end
            if (!line_found) begin
               phase_ms = phase_ms + 1'b1;
               if (phase_ms >= SAMPLE_MS) begin
                  phase_ms = '0;
                  seek_count = seek_count + 1'b1;
                  if (seek_count >= SEEK_LIMIT) begin
                     enter_phase(PH_FAILED);
                     lamp_blink = 1'b1;
                  end
               end
            end
         end
         PH_STRAIGHT: begin
            ld = STRAIGHT_LEFT;
            rd = STRAIGHT_RIGHT;
            count_ms(STRAIGHT_MS, PH_DONE);
         end
         PH_FAILED: begin
            lamp = lamp_blink;
            phase_ms = phase_ms + 1'b1;
            if (phase_ms >= BLINK_MS) begin
               phase_ms = '0;
               lamp_blink = ~lamp_blink;
            end
         end
         default: shown = PH_DONE;
      endcase
      // clamp both duties to full scale
      if (ld > PWM_FULL_SCALE)
         ld = DUTY_W'(PWM_FULL_SCALE);
      if (rd > PWM_FULL_SCALE)
         rd = DUTY_W'(PWM_FULL_SCALE);
      r.left_duty     = ld;
      r.left_forward  = (ld != '0);
      r.right_duty    = rd;
      r.right_forward = (rd != '0);
      r.led_on        = lamp;
      r.phase_now     = shown;
   endtask

   // ---------------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------------

   // random tick, echo widths lean toward zero and toward the trigger limit
   function automatic req_type random_tick();
      req_type t;
      t.line_sensors = 4'($urandom);
      t.echo_ready   = 1'($urandom_range(1));
      t.echo_timeout = ($urandom_range(3) == 0);
      case ($urandom_range(3))
         0:       t.echo_us = ECHO_W'($urandom_range(3));
         1:       t.echo_us = cfg.stop_echo_limit + ECHO_W'($urandom_range(4)) - ECHO_W'(2);
         default: t.echo_us = ECHO_W'($urandom);
      endcase
      return t;
   endfunction

   function automatic logic [DUTY_W-1:0] pick_duty();
      case ($urandom_range(5))
         0:       return '0;
         1:       return 10'd1023;
         2:       return 10'd1000;
         default: return DUTY_W'($urandom_range(1000));
      endcase
   endfunction

   // phase lengths stay short except for the odd full-length one
   function automatic logic [MS_W-1:0] pick_time();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 10'd1;
         2:       return 10'd1023;
         default: return MS_W'($urandom_range(60, 2));
      endcase
   endfunction

   // one transfer on the request channel, with sender gaps per the idle mode
   task automatic send_tick(input req_type t, input logic typed, input rsp_type want);
      rsp_type predicted;
      int      mode;
      int      gap_pct;
      mode = (ticks_sent / 150) % 4;
      idle_mode <= mode;
      gap_pct = (mode == 1) ? 61 : (mode == 3) ? 13 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid        <= 1'b1;
      req.line_sensors <= t.line_sensors;
      req.echo_ready   <= t.echo_ready;
      req.echo_us      <= t.echo_us;
      req.echo_timeout <= t.echo_timeout;
      do
         @(posedge clock);
      while (req.ready !== 1'b1);
      advance_bypass(t, predicted);
      expected_drive.push_back(typed ? want : predicted);
      ticks_sent++;
   endtask

   // stop sending and wait until every owed result has come back
   task automatic drain();
      req.valid <= 1'b0;
      while (expected_drive.size() != 0)
         @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      case (idx)
         REG_STOP_ECHO_LIMIT:  cfg.stop_echo_limit  = data[ECHO_W-1:0];
         REG_SPEED_RUN:        cfg.speed_run        = data[DUTY_W-1:0];
         REG_SPEED_FAST:       cfg.speed_fast       = data[DUTY_W-1:0];
         REG_SPEED_SLOW:       cfg.speed_slow       = data[DUTY_W-1:0];
         REG_SPEED_LEFT_INNER: cfg.speed_left_inner = data[DUTY_W-1:0];
         REG_TIME_VEER_RIGHT:  cfg.time_veer_right  = data[MS_W-1:0];
         REG_TIME_PASS:        cfg.time_pass        = data[MS_W-1:0];
         REG_RETURN_TURN_MS:   cfg.return_turn_ms   = data[MS_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic program_all(input cfg_type c);
      write_reg(REG_STOP_ECHO_LIMIT, c.stop_echo_limit);
      write_reg(REG_SPEED_RUN, CSR_DATA_W'(c.speed_run));
      write_reg(REG_SPEED_FAST, CSR_DATA_W'(c.speed_fast));
      write_reg(REG_SPEED_SLOW, CSR_DATA_W'(c.speed_slow));
      write_reg(REG_SPEED_LEFT_INNER, CSR_DATA_W'(c.speed_left_inner));
      write_reg(REG_TIME_VEER_RIGHT, CSR_DATA_W'(c.time_veer_right));
      write_reg(REG_TIME_PASS, CSR_DATA_W'(c.time_pass));
      write_reg(REG_RETURN_TURN_MS, CSR_DATA_W'(c.return_turn_ms));
   endtask

   // ---------------------------------------------------------------------------------
   // result side
   // ---------------------------------------------------------------------------------

   task automatic flag_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want)
         flag_mismatch($sformatf("%s got %0d, want %0d (result %0d)",
                                 name, got, want, drives_checked));
   endtask

   // receiver stalls per the idle mode
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         case (idle_mode)
            2:       rsp.ready <= ($urandom_range(99) >= 61);
            3:       rsp.ready <= ($urandom_range(99) >= 13);
            default: rsp.ready <= 1'b1;
         endcase
      end
   end

   // every result transfer is matched against the oldest owed drive
   always @(posedge clock) begin : check_drive
      rsp_type want;
      if (!reset && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
         if (expected_drive.size() == 0) begin
            flag_mismatch("result transfer with nothing owed");
         end else begin
            want = expected_drive.pop_front();
            check_field("left_duty", 16'(rsp.left_duty), 16'(want.left_duty));
            check_field("left_forward", 16'(rsp.left_forward), 16'(want.left_forward));
            check_field("right_duty", 16'(rsp.right_duty), 16'(want.right_duty));
            check_field("right_forward", 16'(rsp.right_forward), 16'(want.right_forward));
            check_field("led_on", 16'(rsp.led_on), 16'(want.led_on));
            check_field("phase_now", 16'(rsp.phase_now), 16'(want.phase_now));
         end
         drives_checked++;
      end
   end

   // ---------------------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------------------

   initial begin
      req_type              t;
      cfg_type              c;
      logic                 line_lost;
      logic [CSR_IDX_W-1:0] idx;
      logic [CSR_DATA_W-1:0] v;
      int                   n;

      // all block inputs known from time zero
      reset            <= 1'b1;
      req.valid        <= 1'b0;
      req.line_sensors <= '0;
      req.echo_ready   <= 1'b0;
      req.echo_us      <= '0;
      req.echo_timeout <= 1'b0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;

      // predictor starts from the reset state
      cfg        = '{15'd696, 10'd300, 10'd460, 10'd130, 10'd60, 10'd150, 10'd480, 10'd380};
      bp_phase   = PH_CRUISE;
      phase_ms   = '0;
      seek_count = '0;
      hit_run    = '0;
      lamp_blink = 1'b0;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // opening table under reset registers
      for (int i = 0; i < 10; i++)
         send_tick(OPENING_TICKS[i].stim, OPENING_TICKS[i].typed, OPENING_TICKS[i].want);

      // cruise under several register settings, triggering echoes held back
      for (int k = 0; k < 4; k++) begin
         if (k < 3) begin
            c = CRUISE_SETTINGS[k];
         end else begin
            c.stop_echo_limit  = ECHO_W'($urandom_range(25000));
            c.speed_run        = pick_duty();
            c.speed_fast       = pick_duty();
            c.speed_slow       = pick_duty();
            c.speed_left_inner = pick_duty();
            c.time_veer_right  = MS_W'($urandom);
            c.time_pass        = MS_W'($urandom);
            c.return_turn_ms   = MS_W'($urandom);
         end
         drain();
         program_all(c);
         repeat (CRUISE_TICKS) begin
            do
               t = random_tick();
            while (starts_bypass(t));
            send_tick(t, 1'b0, '0);
         end
      end

      // bypass setup: limit, speeds and phase lengths for the one run this reset allows
      drain();
      case ($urandom_range(4))
         0:       c.stop_echo_limit = 15'd1;
         1:       c.stop_echo_limit = 15'd696;
         2:       c.stop_echo_limit = 15'd25000;
         3:       c.stop_echo_limit = 15'h7FFF;
         default: c.stop_echo_limit = ECHO_W'($urandom_range(25000, 1));
      endcase
      c.speed_run        = pick_duty();
      c.speed_fast       = pick_duty();
      c.speed_slow       = pick_duty();
      c.speed_left_inner = pick_duty();
      c.time_veer_right  = pick_time();
      c.time_pass        = pick_time();
      c.return_turn_ms   = pick_time();
      program_all(c);

      // trigger on one of the window edges
      t = random_tick();
      t.echo_ready   = 1'b1;
      t.echo_timeout = 1'b0;
      t.echo_us      = $urandom_range(1) ? ECHO_W'(1) : c.stop_echo_limit;
      send_tick(t, 1'b1, BRAKE_SHOWN);

      // seek either finds the line or is kept from two hits in a row until it gives up
      line_lost = 1'($urandom_range(1));
      n = 0;
      while (bp_phase != PH_DONE && bp_phase != PH_FAILED) begin
         t = random_tick();
         if (bp_phase == PH_SEEK) begin
            t.line_sensors = ($urandom_range(99) < 40) ? 4'($urandom_range(15, 1)) : 4'd0;
            if (line_lost && phase_ms == '0 && hit_run != '0)
               t.line_sensors = 4'd0;
         end
         send_tick(t, 1'b0, '0);
         n++;
         // rewrite one register mid-sequence, raw wide data now and then on the speeds
         if (n % REWRITE_EVERY == 0) begin
            drain();
            idx = CSR_IDX_W'($urandom_range(7));
            case (idx)
               REG_STOP_ECHO_LIMIT: v = CSR_DATA_W'($urandom);
               REG_TIME_VEER_RIGHT, REG_TIME_PASS, REG_RETURN_TURN_MS:
                  v = CSR_DATA_W'($urandom_range(40));
               default:
                  v = ($urandom_range(3) == 0) ? CSR_DATA_W'($urandom) : 15'(pick_duty());
            endcase
            write_reg(idx, v);
         end
      end

      // end state holds, echoes and probes ignored, lamp blinks if the seek gave up
      repeat (TAIL_TICKS)
         send_tick(random_tick(), 1'b0, '0);

      drain();
      repeat (20) @(posedge clock);
      if (expected_drive.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", expected_drive.size()));

      $display("covered cruise under %0d register writes and one bypass run ending %s",
               reg_writes, (bp_phase == PH_FAILED) ? "in a failed seek" : "on the line");
      $display("%0d ticks sent, %0d results compared, %0d mismatches",
               ticks_sent, drives_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
